// File: src/gre_pkg.sv
// Shared types and constants for the glyph row bit expander.
// Depends on nothing; every other file refers to it by scoped names.
package gre_pkg;

  localparam int COORD_BITS = 10;
  localparam int LEN_BITS   = 10;
  localparam int COLOR_BITS = 16;
  localparam int LANES      = 8;
  localparam int SLOTS      = LANES + 1;   // one run per lane plus the row-end close
  localparam int SLOT_BITS  = 4;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // configuration register indexes
  localparam logic [1:0] REG_FG_COLOR   = 2'd0;
  localparam logic [1:0] REG_BG_COLOR   = 2'd1;
  localparam logic [1:0] REG_TRANSP     = 2'd2;
  localparam logic [1:0] REG_SCALE      = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [LEN_BITS-1:0]   len;
    logic [COLOR_BITS-1:0] color;
  } run_t;

  // what every lane sees of the current item and block state
  typedef struct packed {
    logic [7:0]            font_byte;
    logic [3:0]            nbits;
    logic [7:0]            col;
    logic [COORD_BITS-1:0] pen;
    logic [1:0]            sh;
    logic [LEN_BITS-1:0]   open_len;
    logic [COORD_BITS-1:0] open_start;
    logic                  transp;
    logic [COLOR_BITS-1:0] fg;
    logic [COLOR_BITS-1:0] bg;
  } lane_ctl_t;

  typedef struct packed {
    logic                  emit;
    run_t                  run;
    logic [LEN_BITS-1:0]   after_len;    // open run just after this pixel
    logic [COORD_BITS-1:0] after_start;
  } lane_res_t;

endpackage

// File: src/gre_if.sv
// Handshake channel interfaces: font byte input, pixel run output, config write.
// Depends on gre_pkg.
interface gre_in_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     font_byte;
  logic [3:0]                     bits_used;
  logic [7:0]                     glyph_width;
  logic [gre_pkg::COORD_BITS-1:0] pen_x;
  logic [gre_pkg::COORD_BITS-1:0] row_y;
  logic                           blank_row;
  logic                           last_byte;

  modport source (output valid, font_byte, bits_used, glyph_width, pen_x, row_y,
                  blank_row, last_byte, input ready);
  modport sink (input valid, font_byte, bits_used, glyph_width, pen_x, row_y,
                blank_row, last_byte, output ready);
endinterface

interface gre_out_if;
  logic                           valid;
  logic                           ready;
  logic [gre_pkg::COORD_BITS-1:0] run_x;
  logic [gre_pkg::COORD_BITS-1:0] run_y;
  logic [gre_pkg::LEN_BITS-1:0]   run_length;
  logic [gre_pkg::COLOR_BITS-1:0] run_color;
  logic                           last_run;

  modport source (output valid, run_x, run_y, run_length, run_color, last_run,
                  input ready);
  modport sink (input valid, run_x, run_y, run_length, run_color, last_run,
                output ready);
endinterface

interface gre_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/gre_lane.sv
// One pixel lane: screen x, solid-mode run, and transparent run tracking for
// a single bit of the font byte. Depends on gre_pkg.
module gre_lane (
  input  gre_pkg::lane_ctl_t                 ctl,
  input  logic [2:0]                         lane_idx,
  input  logic [gre_pkg::LEN_BITS-1:0]       prev_len,
  input  logic [gre_pkg::COORD_BITS-1:0]     prev_start,
  output gre_pkg::lane_res_t                 res
);

  logic                           active;
  logic                           pix;
  logic [7:0]                     col_own;
  logic [7:0]                     col_start;
  logic [gre_pkg::COORD_BITS-1:0] x_own;
  logic [gre_pkg::COORD_BITS-1:0] x_start;
  logic [3:0]                     ones;
  logic                           run_on;
  logic                           reach0;
  logic [2:0]                     start_idx;
  logic [5:0]                     span;
  logic [gre_pkg::LEN_BITS:0]     sum;
  logic [gre_pkg::LEN_BITS-1:0]   step;

  assign active  = {1'b0, lane_idx} < ctl.nbits;
  assign pix     = ctl.font_byte[3'd7 - lane_idx];
  assign col_own = ctl.col + {5'b0, lane_idx};
  assign x_own   = ctl.pen + (gre_pkg::COORD_BITS'(col_own) << ctl.sh);
  assign step    = gre_pkg::LEN_BITS'(1) << ctl.sh;

  // consecutive set pixels ending at this lane
  always_comb begin
    ones   = 4'd0;
    run_on = 1'b1;
    for (int n = 0; n < gre_pkg::LANES; n++) begin
      if (3'(n) <= lane_idx) begin
        if (run_on && ctl.font_byte[3'd7 - (lane_idx - 3'(n))]) begin
          ones = ones + 4'd1;
        end else begin
          run_on = 1'b0;
        end
      end
    end
  end

  assign reach0    = (ones == ({1'b0, lane_idx} + 4'd1));
  assign start_idx = reach0 ? 3'd0 : (lane_idx + 3'd1 - ones[2:0]);
  assign col_start = ctl.col + {5'b0, start_idx};
  assign x_start   = ctl.pen + (gre_pkg::COORD_BITS'(col_start) << ctl.sh);
  assign span      = 6'(ones) << ctl.sh;
  assign sum       = {1'b0, ctl.open_len} + (gre_pkg::LEN_BITS + 1)'(span);

  always_comb begin
    res = '0;
    if (reach0 && (ctl.open_len != '0)) begin
      // run carried over from earlier bytes
      res.after_len   = sum[gre_pkg::LEN_BITS] ? gre_pkg::LEN_MAX
                                               : sum[gre_pkg::LEN_BITS-1:0];
      res.after_start = ctl.open_start;
    end else begin
      res.after_len   = gre_pkg::LEN_BITS'(span);
      res.after_start = x_start;
    end

    if (ctl.transp) begin
      res.emit      = active && !pix && (prev_len != '0);
      res.run.x     = prev_start;
      res.run.len   = prev_len;
      res.run.color = ctl.fg;
    end else begin
      res.emit      = active;
      res.run.x     = x_own;
      res.run.len   = step;
      res.run.color = pix ? ctl.fg : ctl.bg;
    end
  end

endmodule

// File: src/gre_drain.sv
// Run buffer and output register: holds the runs of one item and hands
// them out one per cycle in order while out_chan is ready. Depends on gre_pkg and gre_if.
module gre_drain (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  gre_pkg::run_t                  slots [gre_pkg::SLOTS],
  input  logic [gre_pkg::SLOTS-1:0]      mask,
  input  logic [gre_pkg::COORD_BITS-1:0] y,
  output logic                           can_load,
  gre_out_if.source                      out_chan
);

  gre_pkg::run_t                  slots_r [gre_pkg::SLOTS];
  logic [gre_pkg::SLOTS-1:0]      mask_r;
  logic [gre_pkg::SLOTS-1:0]      mask_nxt;
  logic [gre_pkg::SLOTS-1:0]      rest;
  logic [gre_pkg::COORD_BITS-1:0] y_r;
  logic [gre_pkg::SLOT_BITS-1:0]  sel_idx;
  logic                           found;
  logic                           fire;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  gre_pkg::run_t                  out_run_r;
  logic [gre_pkg::COORD_BITS-1:0] out_y_r;
  logic                           out_last_r;

  // lowest pending slot goes next
  always_comb begin
    sel_idx = '0;
    found   = 1'b0;
    for (int i = 0; i < gre_pkg::SLOTS; i++) begin
      if (!found && mask_r[i]) begin
        sel_idx = gre_pkg::SLOT_BITS'(i);
        found   = 1'b1;
      end
    end
  end

  assign rest     = mask_r & ~(gre_pkg::SLOTS'(1) << sel_idx);
  assign fire     = (mask_r != '0) && (!out_valid_r || out_chan.ready);
  assign can_load = (mask_r == '0) || (fire && (rest == '0));

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = mask;
    end else if (fire) begin
      mask_nxt = rest;
    end
    out_valid_nxt = fire ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= slots;
      y_r     <= y;
    end
    if (fire) begin
      out_run_r  <= slots_r[sel_idx];
      out_y_r    <= y_r;
      out_last_r <= (rest == '0);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.run_x      = out_run_r.x;
  assign out_chan.run_y      = out_y_r;
  assign out_chan.run_length = out_run_r.len;
  assign out_chan.run_color  = out_run_r.color;
  assign out_chan.last_run   = out_last_r;

endmodule

// File: src/glyph_row_bit_expander.sv
// Glyph row bit expander top level: config registers, row state, eight
// pixel lanes and the run buffer. Depends on gre_pkg, gre_if, gre_lane, gre_drain.
//
// Usage:
//   in_chan  : one font byte of a glyph row per item (valid/ready).
//   out_chan : pixel runs, one per item, last_run set on the final run of
//              each input item. Items that yield no run give nothing.
//   cfg_chan : register writes (index, data); always ready. Write only while
//              the block is idle.
// Eight lanes look at all bits of a byte at once, so a byte is decoded in
// the cycle it is accepted; its runs (up to eight) leave through the run
// buffer at one per cycle while out_chan is ready. Each run passes from the
// buffer to the output register before out_chan valid rises. The next byte
// is taken in the cycle the last run of the current one moves to the output
// register, so single-run bytes stream at one per cycle while out_chan is
// ready.
// Reset: fg 0xFFFF, bg 0, solid mode, scale 1, column and open run cleared,
// buffer and output empty.
// When out_chan stalls, the output register holds its run and in_chan
// ready drops as soon as the buffer still holds runs of the current byte.
module glyph_row_bit_expander (
  input  logic      clk,
  input  logic      rst_n,
  gre_in_if.sink    in_chan,
  gre_out_if.source out_chan,
  gre_cfg_if.sink   cfg_chan
);

  logic [gre_pkg::COLOR_BITS-1:0] fg_r;
  logic [gre_pkg::COLOR_BITS-1:0] bg_r;
  logic                           transp_r;
  logic [1:0]                     scale_r;

  logic [7:0]                     col_r;
  logic [7:0]                     col_nxt;
  logic [gre_pkg::LEN_BITS-1:0]   open_len_r;
  logic [gre_pkg::LEN_BITS-1:0]   open_len_nxt;
  logic [gre_pkg::COORD_BITS-1:0] open_start_r;
  logic [gre_pkg::COORD_BITS-1:0] open_start_nxt;

  logic                           accept;
  logic                           can_load;
  logic [3:0]                     nbits;
  logic [1:0]                     sh;
  gre_pkg::lane_ctl_t             ctl;
  gre_pkg::lane_res_t             lane_res [gre_pkg::LANES];
  logic [gre_pkg::LEN_BITS-1:0]   fin_len;
  logic [gre_pkg::COORD_BITS-1:0] fin_start;
  gre_pkg::run_t                  slots [gre_pkg::SLOTS];
  logic [gre_pkg::SLOTS-1:0]      mask;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r     <= '1;
      bg_r     <= '0;
      transp_r <= 1'b0;
      scale_r  <= 2'd0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        gre_pkg::REG_FG_COLOR: fg_r     <= cfg_chan.data;
        gre_pkg::REG_BG_COLOR: bg_r     <= cfg_chan.data;
        gre_pkg::REG_TRANSP:   transp_r <= cfg_chan.data[0];
        gre_pkg::REG_SCALE:    scale_r  <= cfg_chan.data[1:0];
        default: ;
      endcase
    end
  end

  assign accept        = in_chan.valid && can_load;
  assign in_chan.ready = can_load;

  assign nbits = (in_chan.bits_used > 4'd8) ? 4'd8 : in_chan.bits_used;
  assign sh    = (scale_r == 2'd3) ? 2'd2 : scale_r;

  always_comb begin
    ctl.font_byte  = in_chan.font_byte;
    ctl.nbits      = nbits;
    ctl.col        = col_r;
    ctl.pen        = in_chan.pen_x;
    ctl.sh         = sh;
    ctl.open_len   = open_len_r;
    ctl.open_start = open_start_r;
    ctl.transp     = transp_r;
    ctl.fg         = fg_r;
    ctl.bg         = bg_r;
  end

  for (genvar i = 0; i < gre_pkg::LANES; i++) begin : g_lane
    if (i == 0) begin : g_first
      gre_lane u_lane (
        .ctl        (ctl),
        .lane_idx   (3'(i)),
        .prev_len   (open_len_r),
        .prev_start (open_start_r),
        .res        (lane_res[i])
      );
    end else begin : g_rest
      gre_lane u_lane (
        .ctl        (ctl),
        .lane_idx   (3'(i)),
        .prev_len   (lane_res[i-1].after_len),
        .prev_start (lane_res[i-1].after_start),
        .res        (lane_res[i])
      );
    end
  end

  // open run after the last pixel of this byte
  always_comb begin
    if (nbits == 4'd0) begin
      fin_len   = open_len_r;
      fin_start = open_start_r;
    end else begin
      fin_len   = lane_res[3'(nbits - 4'd1)].after_len;
      fin_start = lane_res[3'(nbits - 4'd1)].after_start;
    end
  end

  // merge lane results into the run slots
  always_comb begin
    for (int i = 0; i < gre_pkg::LANES; i++) begin
      slots[i] = lane_res[i].run;
      mask[i]  = lane_res[i].emit && !in_chan.blank_row;
    end
    slots[gre_pkg::LANES].x     = fin_start;
    slots[gre_pkg::LANES].len   = fin_len;
    slots[gre_pkg::LANES].color = fg_r;
    mask[gre_pkg::LANES] = transp_r && !in_chan.blank_row && in_chan.last_byte &&
                           (fin_len != '0);
    if (in_chan.blank_row) begin
      slots[0].x     = in_chan.pen_x;
      slots[0].len   = gre_pkg::LEN_BITS'(in_chan.glyph_width) << sh;
      slots[0].color = bg_r;
      mask[0]        = !transp_r && (in_chan.glyph_width != 8'd0);
    end
  end

  always_comb begin
    col_nxt        = col_r + {4'b0, nbits};
    open_len_nxt   = '0;
    open_start_nxt = open_start_r;
    if (in_chan.blank_row) begin
      col_nxt        = 8'd0;
      open_start_nxt = '0;
    end else if (transp_r) begin
      open_len_nxt   = in_chan.last_byte ? '0 : fin_len;
      open_start_nxt = fin_start;
    end
    if (in_chan.last_byte) begin
      col_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      open_len_r   <= '0;
      open_start_r <= '0;
    end else if (accept) begin
      col_r        <= col_nxt;
      open_len_r   <= open_len_nxt;
      open_start_r <= open_start_nxt;
    end
  end

  gre_drain u_drain (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .slots    (slots),
    .mask     (mask),
    .y        (in_chan.row_y),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule
